### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// every macro samples on i_clk and is masked while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property check
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication check, antecedent and consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

### hw/rtl/hrlp_pkg.sv
// types, codes and character constants for the request line parser
// no dependencies; used by hrlp_core and http_request_line_parser_top
package hrlp_pkg;

    localparam int unsigned VERSION_TEXT_LENGTH = 8;
    localparam logic [15:0] LINE_CAPACITY_RESET = 16'd8192;

    localparam logic [3:0] VLEN_SAT   = 4'd9;
    localparam logic [3:0] VLEN_FULL  = 4'(VERSION_TEXT_LENGTH);
    localparam logic [3:0] VPOS_FIVE  = 4'd5;
    localparam logic [3:0] VPOS_SEVEN = 4'd7;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_DASH    = 8'h2d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUEST   = 8'h3f;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef enum logic [3:0] {
        PH_METHOD      = 4'd0,
        PH_PATH        = 4'd1,
        PH_QUERY       = 4'd2,
        PH_FRAGMENT    = 4'd3,
        PH_VERSION     = 4'd4,
        PH_WAIT_LF     = 4'd5,
        PH_DONE        = 4'd6,
        PH_ERR_METHOD  = 4'd7,
        PH_ERR_VERSION = 4'd8,
        PH_ERR_LF      = 4'd9,
        PH_ERR_LONG    = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN         = 3'd0,
        ST_DONE        = 3'd1,
        ST_BAD_METHOD  = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_LF      = 3'd4,
        ST_TOO_LONG    = 3'd5,
        ST_IDLE        = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        PART_METHOD   = 3'd0,
        PART_PATH     = 3'd1,
        PART_QUERY    = 3'd2,
        PART_FRAGMENT = 3'd3,
        PART_VERSION  = 3'd4,
        PART_LINE_END = 3'd5
    } t_part;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_request;
    } t_in_word;

    typedef struct packed {
        logic [7:0] byte_echo;
        logic [2:0] part;
        logic       part_end;
        logic [2:0] status;
        logic       version_1_1;
        logic       query_present;
        logic       fragment_present;
    } t_out_word;

endpackage

### hw/rtl/http_request_line_parser_top.sv
// http request line parser: one input word per cycle when not stalled, one result word per input word
// a result is registered into the main register, or into the skid while the main word waits
// throughput: one word per cycle while o_in_stall is low, set by the single-step parser core
// and a two-entry output buffer (main register plus skid) that accepts one more word while a result waits
// reset: synchronous active low, clears buffer valids and parser state, capacity = 8192
// depends on hrlp_pkg, hrlp_core and assert_macros.svh
`include "assert_macros.svh"

module http_request_line_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hrlp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hrlp_pkg::t_out_word o_out_data
);

    logic [15:0]         r_line_capacity;
    logic                in_accept;
    logic                out_take;
    hrlp_pkg::t_out_word result;
    hrlp_pkg::t_out_word r_main;
    hrlp_pkg::t_out_word r_skid;
    logic                r_main_valid;
    logic                r_skid_valid;

    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_main_valid && !i_out_stall;
    assign o_out_valid = r_main_valid;
    assign o_out_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_capacity <= hrlp_pkg::LINE_CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_line_capacity <= i_cfg_wdata;
        end
    end

    hrlp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_word          (i_in_data),
        .i_line_capacity (r_line_capacity),
        .o_result        (result)
    );

    // output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= in_accept;
            end
        end else if (in_accept) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else begin
                r_main <= result;
            end
        end else if (in_accept) begin
            if (r_main_valid) begin
                r_skid <= result;
            end else begin
                r_main <= result;
            end
        end
    end

    `ASSERT_IMPL(a_skid_needs_main, r_skid_valid, r_main_valid, "skid word without main word")
    `ASSERT_IMPL(a_skid_fill_stalled, $rose(r_skid_valid), $past(i_out_stall), "skid filled without stall")
    `ASSERT_IMPL(a_no_idle_status, r_main_valid, r_main.status != hrlp_pkg::ST_IDLE, "idle status produced")
    `ASSERT_IMPL(a_part_end_tagged, r_main_valid && r_main.part_end, r_main.part != hrlp_pkg::PART_LINE_END, "separator on line end")

endmodule

### hw/rtl/hrlp_core.sv
// per-byte parser state machine: phase, budget and version tracking
// depends on hrlp_pkg; result word is combinational from the current state and input
module hrlp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  hrlp_pkg::t_in_word  i_word,
    input  logic [15:0]         i_line_capacity,
    output hrlp_pkg::t_out_word o_result
);

    hrlp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [15:0] r_cap, n_cap, e_cap;
    logic [3:0]  r_vlen, n_vlen, e_vlen;
    logic [7:0]  r_c5, n_c5, e_c5;
    logic [7:0]  r_c7, n_c7, e_c7;
    logic        r_v11, n_v11, e_v11;
    logic        r_q, n_q, e_q;
    logic        r_f, n_f, e_f;
    logic        spends;
    logic        bad;
    logic [7:0]  c;
    hrlp_pkg::t_part   part;
    logic              pend;
    hrlp_pkg::t_status status;

    assign c = i_word.data_byte;

    // start flag restarts the line before this byte
    always_comb begin
        if (i_word.start_of_request) begin
            e_phase = hrlp_pkg::PH_METHOD;
            e_cap   = i_line_capacity;
            e_vlen  = 4'd0;
            e_c5    = 8'd0;
            e_c7    = 8'd0;
            e_v11   = 1'b0;
            e_q     = 1'b0;
            e_f     = 1'b0;
        end else begin
            e_phase = r_phase;
            e_cap   = r_cap;
            e_vlen  = r_vlen;
            e_c5    = r_c5;
            e_c7    = r_c7;
            e_v11   = r_v11;
            e_q     = r_q;
            e_f     = r_f;
        end
    end

    // next state
    always_comb begin
        n_phase = e_phase;
        n_cap   = e_cap;
        n_vlen  = e_vlen;
        n_c5    = e_c5;
        n_c7    = e_c7;
        n_v11   = e_v11;
        n_q     = e_q;
        n_f     = e_f;
        spends  = 1'b0;
        bad     = 1'b0;
        unique case (e_phase)
            hrlp_pkg::PH_METHOD: begin
                if ((c >= hrlp_pkg::CH_UPPER_A && c <= hrlp_pkg::CH_UPPER_Z)
                        || c == hrlp_pkg::CH_DASH) begin
                    spends = 1'b1;
                end else if (c == hrlp_pkg::CH_SPACE) begin
                    spends  = 1'b1;
                    n_phase = hrlp_pkg::PH_PATH;
                end else begin
                    bad     = 1'b1;
                    n_phase = hrlp_pkg::PH_ERR_METHOD;
                end
            end
            hrlp_pkg::PH_PATH: begin
                spends = 1'b1;
                if (c == hrlp_pkg::CH_QUEST) begin
                    n_q     = 1'b1;
                    n_phase = hrlp_pkg::PH_QUERY;
                end else if (c == hrlp_pkg::CH_HASH) begin
                    n_f     = 1'b1;
                    n_phase = hrlp_pkg::PH_FRAGMENT;
                end else if (c == hrlp_pkg::CH_SPACE) begin
                    n_phase = hrlp_pkg::PH_VERSION;
                end
            end
            hrlp_pkg::PH_QUERY: begin
                spends = 1'b1;
                if (c == hrlp_pkg::CH_HASH) begin
                    n_f     = 1'b1;
                    n_phase = hrlp_pkg::PH_FRAGMENT;
                end else if (c == hrlp_pkg::CH_SPACE) begin
                    n_phase = hrlp_pkg::PH_VERSION;
                end
            end
            hrlp_pkg::PH_FRAGMENT: begin
                spends = 1'b1;
                if (c == hrlp_pkg::CH_SPACE) begin
                    n_phase = hrlp_pkg::PH_VERSION;
                end
            end
            hrlp_pkg::PH_VERSION: begin
                if (c == hrlp_pkg::CH_CR) begin
                    if (e_vlen == hrlp_pkg::VLEN_FULL && e_c5 == hrlp_pkg::CH_ONE
                            && (e_c7 == hrlp_pkg::CH_ONE || e_c7 == hrlp_pkg::CH_ZERO)) begin
                        n_v11   = (e_c7 == hrlp_pkg::CH_ONE);
                        n_phase = hrlp_pkg::PH_WAIT_LF;
                    end else begin
                        n_phase = hrlp_pkg::PH_ERR_VERSION;
                    end
                end else begin
                    spends = 1'b1;
                    if (e_vlen == hrlp_pkg::VPOS_FIVE) begin
                        n_c5 = c;
                    end
                    if (e_vlen == hrlp_pkg::VPOS_SEVEN) begin
                        n_c7 = c;
                    end
                    if (e_vlen < hrlp_pkg::VLEN_SAT) begin
                        n_vlen = e_vlen + 4'd1;
                    end
                end
            end
            hrlp_pkg::PH_WAIT_LF: begin
                n_phase = (c == hrlp_pkg::CH_LF) ? hrlp_pkg::PH_DONE : hrlp_pkg::PH_ERR_LF;
            end
            default: begin
            end
        endcase
        // budget spent by stored bytes; last unit trips too long
        if (spends && !bad) begin
            if (e_cap <= 16'd1) begin
                n_cap   = 16'd0;
                n_phase = hrlp_pkg::PH_ERR_LONG;
            end else begin
                n_cap = e_cap - 16'd1;
            end
        end
    end

    // result tags
    always_comb begin
        part = hrlp_pkg::PART_LINE_END;
        pend = 1'b0;
        unique case (e_phase)
            hrlp_pkg::PH_METHOD: begin
                part = hrlp_pkg::PART_METHOD;
                pend = (c == hrlp_pkg::CH_SPACE);
            end
            hrlp_pkg::PH_PATH: begin
                part = hrlp_pkg::PART_PATH;
                pend = (c == hrlp_pkg::CH_QUEST) || (c == hrlp_pkg::CH_HASH)
                    || (c == hrlp_pkg::CH_SPACE);
            end
            hrlp_pkg::PH_QUERY: begin
                part = hrlp_pkg::PART_QUERY;
                pend = (c == hrlp_pkg::CH_HASH) || (c == hrlp_pkg::CH_SPACE);
            end
            hrlp_pkg::PH_FRAGMENT: begin
                part = hrlp_pkg::PART_FRAGMENT;
                pend = (c == hrlp_pkg::CH_SPACE);
            end
            hrlp_pkg::PH_VERSION: begin
                part = hrlp_pkg::PART_VERSION;
                pend = (c == hrlp_pkg::CH_CR);
            end
            default: begin
            end
        endcase
        unique case (n_phase)
            hrlp_pkg::PH_DONE:        status = hrlp_pkg::ST_DONE;
            hrlp_pkg::PH_ERR_METHOD:  status = hrlp_pkg::ST_BAD_METHOD;
            hrlp_pkg::PH_ERR_VERSION: status = hrlp_pkg::ST_BAD_VERSION;
            hrlp_pkg::PH_ERR_LF:      status = hrlp_pkg::ST_BAD_LF;
            hrlp_pkg::PH_ERR_LONG:    status = hrlp_pkg::ST_TOO_LONG;
            default:                  status = hrlp_pkg::ST_RUN;
        endcase
    end

    assign o_result.byte_echo        = c;
    assign o_result.part             = part;
    assign o_result.part_end         = pend;
    assign o_result.status           = status;
    assign o_result.version_1_1      = n_v11;
    assign o_result.query_present    = n_q;
    assign o_result.fragment_present = n_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrlp_pkg::PH_METHOD;
            r_cap   <= hrlp_pkg::LINE_CAPACITY_RESET;
            r_vlen  <= 4'd0;
            r_c5    <= 8'd0;
            r_c7    <= 8'd0;
            r_v11   <= 1'b0;
            r_q     <= 1'b0;
            r_f     <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cap   <= n_cap;
            r_vlen  <= n_vlen;
            r_c5    <= n_c5;
            r_c7    <= n_c7;
            r_v11   <= n_v11;
            r_q     <= n_q;
            r_f     <= n_f;
        end
    end

endmodule
